### rtl/cbc_pkg.sv
// ----------------------------------------------------------------------------
// cbc_pkg
// Shared types, widths and constants of the cascaded balance controller.
// ----------------------------------------------------------------------------
package cbc_pkg;

   localparam int PW    = 86;   // product accumulator width
   localparam int MXW   = 52;   // multiplier x operand width
   localparam int MYW   = 33;   // multiplier y operand width
   localparam int MXL   = 26;   // low slice of x per partial product
   localparam int DVW   = 70;   // dividend magnitude width
   localparam int DVSW  = 28;   // divisor width
   localparam int REQ_W = 96;
   localparam int RSP_W = 48;
   localparam int CSR_IW = 3;

   // period scaling: floor(x / 1e6) by two reciprocal passes and one fix-up
   localparam int SC_PRE = 20;  // pre-shift of x before the first pass
   localparam int SC_SH1 = 31;  // post-shift of the first pass
   localparam int SC_SH2 = 51;  // post-shift of the second pass

   localparam logic signed [MYW-1:0] SENSOR_K = 33'sd40212386;
   localparam logic signed [MYW-1:0] MICRO_Y  = 33'sd1000000;
   localparam logic signed [MYW-1:0] RECIP_Y  = 33'sd2251799813;  // floor(2^51 / 1e6)
   localparam logic signed [39:0]    AVG_GAIN = 40'sd93;

   typedef enum logic [CSR_IW-1:0] {
      CSR_ANGLE_OFFSET = 3'd0,
      CSR_WAKEUP_ANGLE = 3'd1,
      CSR_DEAD_ANGLE   = 3'd2,
      CSR_SPEED_GAIN_P = 3'd3,
      CSR_SPEED_GAIN_I = 3'd4,
      CSR_ANGLE_GAIN_P = 3'd5,
      CSR_ANGLE_GAIN_D = 3'd6
   } csr_idx_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_GATE, ST_CHK, ST_SENS_MUL, ST_SENS_DIV, ST_SENS_CAP, ST_EST,
      ST_SMOOTH, ST_SERR, ST_SUM, ST_I_MUL, ST_SP_MUL, ST_SC_Q1, ST_SC_M1,
      ST_SC_Q2, ST_SC_M2, ST_P_MUL,
      ST_TGT, ST_AERR, ST_D_MUL, ST_D2_MUL, ST_D_DIV, ST_AP_MUL, ST_INCR,
      ST_MEAN, ST_WHEEL, ST_DONE, ST_WAIT
   } state_type;

   typedef enum logic [4:0] {
      SP_NONE, SP_LOAD, SP_GATE, SP_SENS_MUL, SP_SENS_DIV, SP_SENS_CAP, SP_EST,
      SP_SMOOTH, SP_SERR, SP_SUM, SP_I_MUL, SP_SP_MUL, SP_SC_Q1, SP_SC_M1,
      SP_SC_Q2, SP_SC_M2, SP_P_MUL,
      SP_TGT, SP_AERR, SP_D_MUL, SP_D2_MUL, SP_D_DIV, SP_AP_MUL, SP_INCR,
      SP_MEAN, SP_WHEEL, SP_OUT
   } step_type;

   typedef struct packed {
      step_type step;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic en;
   } status_type;

   function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
      logic signed [PW-1:0] hi;
      logic signed [PW-1:0] lo;
      hi = PW'(33'sh07FFFFFFF);
      lo = -hi - PW'(1);
      if (v > hi) begin
         return 32'(hi);
      end else if (v < lo) begin
         return 32'(lo);
      end
      return 32'(v);
   endfunction

endpackage

### rtl/cbc_mul.sv
// ----------------------------------------------------------------------------
// cbc_mul
// Shared signed multiplier, low and high partial products accumulated in turn.
// ----------------------------------------------------------------------------
module cbc_mul (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [cbc_pkg::MXW-1:0]    x,
   input  logic signed [cbc_pkg::MYW-1:0]    y,
   output logic                              busy,
   output logic signed [cbc_pkg::PW-1:0]     prod
);
   import cbc_pkg::*;

   logic [1:0]                ph_ff, ph_in;
   logic signed [MXW-1:0]     mx_ff;
   logic signed [MYW-1:0]     my_ff;
   logic signed [PW-1:0]      acc_ff, acc_in;
   logic signed [MXL:0]       xl;
   logic signed [MXW-MXL-1:0] xh;
   logic signed [MXL+MYW:0]   pl;
   logic signed [MXW-MXL+MYW-1:0] ph;

   assign xl = $signed({1'b0, mx_ff[MXL-1:0]});
   assign xh = mx_ff[MXW-1:MXL];
   assign pl = (MXL+MYW+1)'(xl) * (MXL+MYW+1)'(my_ff);
   assign ph = (MXW-MXL+MYW)'(xh) * (MXW-MXL+MYW)'(my_ff);

   always_comb begin
      ph_in  = ph_ff;
      acc_in = acc_ff;
      if (start) begin
         ph_in = 2'd1;
      end else if (ph_ff == 2'd1) begin
         acc_in = PW'(pl);
         ph_in  = 2'd2;
      end else if (ph_ff == 2'd2) begin
         acc_in = acc_ff + (PW'(ph) <<< MXL);
         ph_in  = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= 2'd0;
      end else begin
         ph_ff <= ph_in;
      end
      if (start) begin
         mx_ff <= x;
         my_ff <= y;
      end
      acc_ff <= acc_in;
   end

   assign busy = (ph_ff != 2'd0);
   assign prod = acc_ff;

endmodule

### rtl/cbc_div.sv
// ----------------------------------------------------------------------------
// cbc_div
// Shared restoring divider, one quotient bit per cycle, floored result.
// ----------------------------------------------------------------------------
module cbc_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [cbc_pkg::PW-1:0]     dividend,
   input  logic [cbc_pkg::DVSW-1:0]          divisor,
   output logic                              busy,
   output logic signed [cbc_pkg::DVW:0]      quot
);
   import cbc_pkg::*;

   localparam int CW = $clog2(DVW + 1);

   logic              busy_ff, busy_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              neg_ff;
   logic [DVW-1:0]    quo_ff, quo_in;
   logic [DVSW-1:0]   rem_ff, rem_in;
   logic [DVSW-1:0]   dvs_ff;
   logic [DVSW:0]     rsh;
   logic [DVSW:0]     rdf;
   logic signed [PW-1:0] mag;
   logic [DVW:0]      qinc;

   assign mag = dividend[PW-1] ? -dividend : dividend;
   assign rsh = {rem_ff, quo_ff[DVW-1]};
   assign rdf = rsh - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DVW);
         quo_in  = DVW'(mag);
         rem_in  = '0;
      end else if (busy_ff) begin
         if (!rdf[DVSW]) begin
            rem_in = rdf[DVSW-1:0];
            quo_in = {quo_ff[DVW-2:0], 1'b1};
         end else begin
            rem_in = rsh[DVSW-1:0];
            quo_in = {quo_ff[DVW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      if (start) begin
         neg_ff <= dividend[PW-1];
         dvs_ff <= divisor;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign qinc = {1'b0, quo_ff} + (DVW+1)'(rem_ff != '0);
   assign quot = neg_ff ? -$signed(qinc) : $signed({1'b0, quo_ff});
   assign busy = busy_ff;

endmodule

### rtl/cbc_dp.sv
// ----------------------------------------------------------------------------
// cbc_dp
// Datapath: settings, loop state, estimator and PI/PD arithmetic, result beat.
// ----------------------------------------------------------------------------
module cbc_dp #(
   parameter int FRAC_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  cbc_pkg::cmd_type                cmd,
   output cbc_pkg::status_type             status,
   input  logic                            csr_valid,
   input  logic [cbc_pkg::CSR_IW-1:0]      csr_index,
   input  logic [31:0]                     csr_data,
   input  logic [cbc_pkg::REQ_W-1:0]       req_tdata,
   output logic [cbc_pkg::RSP_W-1:0]       rsp_tdata
);
   import cbc_pkg::*;

   localparam int SW  = FRAC_BITS + 18;
   localparam int SAW = SW + 15;
   localparam logic signed [SAW-1:0] SUM_LIM = SAW'(100000) <<< FRAC_BITS;
   localparam logic signed [32:0]    SPD_LIM = 33'(6) <<< FRAC_BITS;
   localparam logic signed [PW-1:0]  DPR_LIM = PW'(1) <<< 40;
   localparam logic signed [DVW:0]   D_LIM   = (DVW+1)'((1 << FRAC_BITS) / 5);

   logic signed [24:0] off_ff;
   logic [23:0]        wake_ff, dead_ff;
   logic signed [31:0] gsp_ff, gsi_ff, gap_ff, gad_ff;

   logic signed [25:0] ang_ff, ang_in, lang_ff, lang_in;
   logic [19:0]        per_ff, per_in;
   logic signed [24:0] tsp_ff, tsp_in;
   logic signed [20:0] turn_ff, turn_in;
   logic signed [31:0] sm_ff, sm_in, lae_ff, lae_in, mean_ff, mean_in;
   logic signed [31:0] lw_ff, lw_in, rw_ff, rw_in;
   logic signed [SW-1:0] sum_ff, sum_in;
   logic               en_ff, en_in;

   logic signed [36:0] avg_ff, avg_in;
   logic signed [31:0] sens_ff, sens_in, est_ff, est_in, serr_ff, serr_in;
   logic signed [31:0] tgt_ff, tgt_in, aerr_ff, aerr_in, incr_ff, incr_in;
   logic signed [31:0] dterm_ff, dterm_in;
   logic signed [DVW:0] tsc_ff, tsc_in;
   logic signed [PW-1:0] xs_ff, xs_in;
   logic [RSP_W-1:0]   rsp_ff, rsp_in;

   logic               mul_go, div_go, mul_busy, div_busy;
   logic signed [MXW-1:0] mx;
   logic signed [MYW-1:0] my;
   logic signed [PW-1:0]  prod, sh;
   logic [DVSW-1:0]    dvs;
   logic signed [DVW:0] quot;

   logic [25:0]        mag;
   logic signed [39:0] wsum;
   logic signed [32:0] s2, mx33;
   logic signed [SAW-1:0] sum_x;
   logic signed [PW-1:0]  dpc;
   logic signed [PW-1:0]  rdiff;

   assign sh   = prod >>> FRAC_BITS;
   assign mag  = ang_ff[25] ? 26'(-ang_ff) : ang_ff;
   assign wsum = 40'(lw_ff) + 40'(rw_ff);
   assign s2   = 33'(sm_ff) + 33'(est_ff);
   assign mx33 = 33'(mean_ff) + 33'(incr_ff);
   assign sum_x = SAW'(sum_ff) + SAW'(serr_ff);
   assign dpc  = (sh > DPR_LIM) ? DPR_LIM : ((sh < -DPR_LIM) ? -DPR_LIM : sh);
   assign rdiff = xs_ff - prod;

   cbc_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_go),
      .x     (mx),
      .y     (my),
      .busy  (mul_busy),
      .prod  (prod)
   );

   cbc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go),
      .dividend (prod),
      .divisor  (dvs),
      .busy     (div_busy),
      .quot     (quot)
   );

   always_comb begin
      mul_go = 1'b0;
      div_go = 1'b0;
      mx     = '0;
      my     = '0;
      dvs    = '0;
      unique case (cmd.step)
         SP_SENS_MUL: begin
            mul_go = 1'b1;
            mx = MXW'(ang_ff) - MXW'(lang_ff);
            my = SENSOR_K;
         end
         SP_SENS_DIV: begin
            div_go = 1'b1;
            dvs = {per_ff, 8'd0};
         end
         SP_I_MUL: begin
            mul_go = 1'b1;
            mx = MXW'(sum_ff);
            my = MYW'(gsi_ff);
         end
         SP_SP_MUL: begin
            mul_go = 1'b1;
            mx = MXW'(sh);
            my = $signed({13'd0, per_ff});
         end
         SP_SC_Q1: begin
            mul_go = 1'b1;
            mx = MXW'(prod >>> SC_PRE);
            my = RECIP_Y;
         end
         SP_SC_M1: begin
            mul_go = 1'b1;
            mx = MXW'(prod >>> SC_SH1);
            my = MICRO_Y;
         end
         SP_SC_Q2: begin
            mul_go = 1'b1;
            mx = MXW'(rdiff);
            my = RECIP_Y;
         end
         SP_SC_M2: begin
            mul_go = 1'b1;
            mx = MXW'(prod >>> SC_SH2);
            my = MICRO_Y;
         end
         SP_P_MUL: begin
            mul_go = 1'b1;
            mx = MXW'(serr_ff);
            my = MYW'(gsp_ff);
         end
         SP_D_MUL: begin
            mul_go = 1'b1;
            mx = MXW'(aerr_ff) - MXW'(lae_ff);
            my = MYW'(gad_ff);
         end
         SP_D2_MUL: begin
            mul_go = 1'b1;
            mx = MXW'(dpc);
            my = MICRO_Y;
         end
         SP_D_DIV: begin
            div_go = 1'b1;
            dvs = DVSW'(per_ff);
         end
         SP_AP_MUL: begin
            mul_go = 1'b1;
            mx = MXW'(aerr_ff);
            my = MYW'(gap_ff);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      ang_in = ang_ff;   lang_in = lang_ff;  per_in = per_ff;
      tsp_in = tsp_ff;   turn_in = turn_ff;  sm_in = sm_ff;
      lae_in = lae_ff;   mean_in = mean_ff;  lw_in = lw_ff;
      rw_in = rw_ff;     sum_in = sum_ff;    en_in = en_ff;
      avg_in = avg_ff;   sens_in = sens_ff;  est_in = est_ff;
      serr_in = serr_ff; tgt_in = tgt_ff;    aerr_in = aerr_ff;
      incr_in = incr_ff; dterm_in = dterm_ff; tsc_in = tsc_ff;
      xs_in = xs_ff;
      rsp_in = rsp_ff;
      unique case (cmd.step)
         SP_LOAD: begin
            ang_in  = 26'($signed(req_tdata[24:0])) + 26'(off_ff);
            per_in  = (req_tdata[44:25] == 20'd0) ? 20'd1 : req_tdata[44:25];
            tsp_in  = $signed(req_tdata[69:45]);
            turn_in = $signed(req_tdata[90:70]);
         end
         SP_GATE: begin
            avg_in = 37'((wsum * AVG_GAIN) >>> 3);
            if (mag < {2'b00, wake_ff}) begin
               en_in = 1'b1;
            end
            if (mag > {2'b00, dead_ff}) begin
               en_in   = 1'b0;
               mean_in = '0;
               lw_in   = '0;
               rw_in   = '0;
            end
         end
         SP_SENS_CAP: sens_in = sat32(PW'(quot));
         SP_EST:      est_in  = sat32(PW'(sens_ff) - PW'(avg_ff));
         SP_SMOOTH:   sm_in   = 32'(s2 >>> 1);
         SP_SERR:     serr_in = sat32(PW'(tsp_ff) - PW'(sm_ff));
         SP_SUM: begin
            if (sum_x > SUM_LIM) begin
               sum_in = SW'(SUM_LIM);
            end else if (sum_x < -SUM_LIM) begin
               sum_in = SW'(-SUM_LIM);
            end else begin
               sum_in = SW'(sum_x);
            end
         end
         SP_SC_Q1:    xs_in   = prod;
         SP_SC_M1:    tsc_in  = (DVW+1)'(prod >>> SC_SH1);
         SP_SC_Q2:    xs_in   = rdiff;
         SP_SC_M2:    tsc_in  = tsc_ff + (DVW+1)'(prod >>> SC_SH2);
         SP_P_MUL: begin
            // remainder is within one divisor of range
            if (rdiff[PW-1]) begin
               tsc_in = tsc_ff - (DVW+1)'(1);
            end else if (rdiff >= PW'(MICRO_Y)) begin
               tsc_in = tsc_ff + (DVW+1)'(1);
            end
         end
         SP_TGT:      tgt_in  = sat32(sh + PW'(tsc_ff));
         SP_AERR:     aerr_in = sat32(PW'(tgt_ff) - PW'(ang_ff));
         SP_AP_MUL: begin
            if (quot > D_LIM) begin
               dterm_in = 32'(D_LIM);
            end else if (quot < -D_LIM) begin
               dterm_in = 32'(-D_LIM);
            end else begin
               dterm_in = 32'(quot);
            end
         end
         SP_INCR: begin
            incr_in = sat32(sh + PW'(dterm_ff));
            lae_in  = aerr_ff;
         end
         SP_MEAN: begin
            if (mx33 > SPD_LIM) begin
               mean_in = 32'(SPD_LIM);
            end else if (mx33 < -SPD_LIM) begin
               mean_in = 32'(-SPD_LIM);
            end else begin
               mean_in = 32'(mx33);
            end
         end
         SP_WHEEL: begin
            lw_in = mean_ff - 32'(turn_ff);
            rw_in = mean_ff + 32'(turn_ff);
         end
         SP_OUT: begin
            rsp_in  = {5'd0, en_ff, rw_ff[20:0], lw_ff[20:0]};
            lang_in = ang_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff  <= '0;
         wake_ff <= 24'(5 << FRAC_BITS);
         dead_ff <= 24'(40 << FRAC_BITS);
         gsp_ff  <= '0;
         gsi_ff  <= '0;
         gap_ff  <= '0;
         gad_ff  <= '0;
         lang_ff <= '0;
         sm_ff   <= '0;
         sum_ff  <= '0;
         lae_ff  <= '0;
         mean_ff <= '0;
         lw_ff   <= '0;
         rw_ff   <= '0;
         en_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_idx_type'(csr_index))
               CSR_ANGLE_OFFSET: off_ff  <= csr_data[24:0];
               CSR_WAKEUP_ANGLE: wake_ff <= csr_data[23:0];
               CSR_DEAD_ANGLE:   dead_ff <= csr_data[23:0];
               CSR_SPEED_GAIN_P: gsp_ff  <= csr_data;
               CSR_SPEED_GAIN_I: gsi_ff  <= csr_data;
               CSR_ANGLE_GAIN_P: gap_ff  <= csr_data;
               CSR_ANGLE_GAIN_D: gad_ff  <= csr_data;
               default: begin
               end
            endcase
         end
         lang_ff <= lang_in;
         sm_ff   <= sm_in;
         sum_ff  <= sum_in;
         lae_ff  <= lae_in;
         mean_ff <= mean_in;
         lw_ff   <= lw_in;
         rw_ff   <= rw_in;
         en_ff   <= en_in;
      end
      ang_ff   <= ang_in;
      per_ff   <= per_in;
      tsp_ff   <= tsp_in;
      turn_ff  <= turn_in;
      avg_ff   <= avg_in;
      sens_ff  <= sens_in;
      est_ff   <= est_in;
      serr_ff  <= serr_in;
      tgt_ff   <= tgt_in;
      aerr_ff  <= aerr_in;
      incr_ff  <= incr_in;
      dterm_ff <= dterm_in;
      tsc_ff   <= tsc_in;
      xs_ff    <= xs_in;
      rsp_ff   <= rsp_in;
   end

   assign status.busy = mul_busy | div_busy;
   assign status.en   = en_ff;
   assign rsp_tdata   = rsp_ff;

endmodule

### rtl/cbc_ctrl.sv
// ----------------------------------------------------------------------------
// cbc_ctrl
// Sequencer: steps the datapath through one sample and owns the request and result handshakes.
// ----------------------------------------------------------------------------
module cbc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output cbc_pkg::cmd_type      cmd,
   input  cbc_pkg::status_type   status
);
   import cbc_pkg::*;

   state_type state_ff, state_in, ret_ff, ret_in;
   logic      rv_ff, rv_in;
   logic      slot_free;

   assign slot_free = !rv_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_tvalid) state_in = ST_GATE;
         ST_GATE:     state_in = ST_CHK;
         ST_CHK:      state_in = status.en ? ST_SENS_MUL : ST_DONE;
         ST_SENS_MUL: begin state_in = ST_WAIT; ret_in = ST_SENS_DIV; end
         ST_SENS_DIV: begin state_in = ST_WAIT; ret_in = ST_SENS_CAP; end
         ST_SENS_CAP: state_in = ST_EST;
         ST_EST:      state_in = ST_SMOOTH;
         ST_SMOOTH:   state_in = ST_SERR;
         ST_SERR:     state_in = ST_SUM;
         ST_SUM:      state_in = ST_I_MUL;
         ST_I_MUL:    begin state_in = ST_WAIT; ret_in = ST_SP_MUL; end
         ST_SP_MUL:   begin state_in = ST_WAIT; ret_in = ST_SC_Q1; end
         ST_SC_Q1:    begin state_in = ST_WAIT; ret_in = ST_SC_M1; end
         ST_SC_M1:    begin state_in = ST_WAIT; ret_in = ST_SC_Q2; end
         ST_SC_Q2:    begin state_in = ST_WAIT; ret_in = ST_SC_M2; end
         ST_SC_M2:    begin state_in = ST_WAIT; ret_in = ST_P_MUL; end
         ST_P_MUL:    begin state_in = ST_WAIT; ret_in = ST_TGT; end
         ST_TGT:      state_in = ST_AERR;
         ST_AERR:     state_in = ST_D_MUL;
         ST_D_MUL:    begin state_in = ST_WAIT; ret_in = ST_D2_MUL; end
         ST_D2_MUL:   begin state_in = ST_WAIT; ret_in = ST_D_DIV; end
         ST_D_DIV:    begin state_in = ST_WAIT; ret_in = ST_AP_MUL; end
         ST_AP_MUL:   begin state_in = ST_WAIT; ret_in = ST_INCR; end
         ST_INCR:     state_in = ST_MEAN;
         ST_MEAN:     state_in = ST_WHEEL;
         ST_WHEEL:    state_in = ST_DONE;
         ST_DONE:     if (slot_free) state_in = ST_IDLE;
         ST_WAIT:     if (!status.busy) state_in = ret_ff;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.step   = SP_NONE;
      req_tready = 1'b0;
      rv_in      = rv_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) cmd.step = SP_LOAD;
         end
         ST_GATE:     cmd.step = SP_GATE;
         ST_SENS_MUL: cmd.step = SP_SENS_MUL;
         ST_SENS_DIV: cmd.step = SP_SENS_DIV;
         ST_SENS_CAP: cmd.step = SP_SENS_CAP;
         ST_EST:      cmd.step = SP_EST;
         ST_SMOOTH:   cmd.step = SP_SMOOTH;
         ST_SERR:     cmd.step = SP_SERR;
         ST_SUM:      cmd.step = SP_SUM;
         ST_I_MUL:    cmd.step = SP_I_MUL;
         ST_SP_MUL:   cmd.step = SP_SP_MUL;
         ST_SC_Q1:    cmd.step = SP_SC_Q1;
         ST_SC_M1:    cmd.step = SP_SC_M1;
         ST_SC_Q2:    cmd.step = SP_SC_Q2;
         ST_SC_M2:    cmd.step = SP_SC_M2;
         ST_P_MUL:    cmd.step = SP_P_MUL;
         ST_TGT:      cmd.step = SP_TGT;
         ST_AERR:     cmd.step = SP_AERR;
         ST_D_MUL:    cmd.step = SP_D_MUL;
         ST_D2_MUL:   cmd.step = SP_D2_MUL;
         ST_D_DIV:    cmd.step = SP_D_DIV;
         ST_AP_MUL:   cmd.step = SP_AP_MUL;
         ST_INCR:     cmd.step = SP_INCR;
         ST_MEAN:     cmd.step = SP_MEAN;
         ST_WHEEL:    cmd.step = SP_WHEEL;
         ST_DONE: begin
            if (slot_free) begin
               cmd.step = SP_OUT;
               rv_in    = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         rv_ff    <= rv_in;
      end
   end

   assign rsp_tvalid = rv_ff;

endmodule

### rtl/cascaded_balance_controller_top.sv
// with motors disabled a sample skips the estimator and loop arithmetic and goes straight to the result
// throughput: one sample at a time; the two divider passes take most of the time per sample
// the result sits in an output register, so the next beat is taken while it waits
// reset: synchronous, active high; settings and loop state return to defaults at once
// ----------------------------------------------------------------------------
// cascaded_balance_controller_top
// Cascaded PI speed / PD angle balance loop for a two-wheeled pendulum.
// ----------------------------------------------------------------------------
module cascaded_balance_controller_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // tilt_angle, period_us, target_speed, turn_rate
   input  logic [cbc_pkg::REQ_W-1:0]   req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // left_speed, right_speed, motor_on
   output logic [cbc_pkg::RSP_W-1:0]   rsp_tdata,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [cbc_pkg::CSR_IW-1:0]  csr_index,
   input  logic [31:0]                 csr_data
);
   import cbc_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   cbc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   cbc_dp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("beat accepted while a sample is in flight");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && status.busy))
      else $error("arithmetic unit busy while idle");

   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result beat without a sample in flight");

endmodule
